// File: hdl/fuzzy_subsequence_scorer_defines.svh
// ----------------------------------------------------------------------------
// Fuzzy subsequence scorer assertion macros
// Shared concurrent assertion forms, sampled on clk_i, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef FUZZY_SUBSEQUENCE_SCORER_DEFINES_SVH
`define FUZZY_SUBSEQUENCE_SCORER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FSS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/fss_pkg.sv
// ----------------------------------------------------------------------------
// Fuzzy subsequence scorer package
// Widths, constants, register indexes and the result type of the scorer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fss_pkg;

  localparam int unsigned PATTERN_MAX = 8;
  localparam int unsigned TEXT_MAX    = 4096;

  localparam int unsigned CHAR_W  = 16;
  localparam int unsigned LEN_W   = 4;
  localparam int unsigned WORD_W  = 64;
  localparam int unsigned SLOT_W  = 3;
  localparam int unsigned POS_W   = $clog2(TEXT_MAX + 1);
  localparam int unsigned IDX_W   = $clog2(TEXT_MAX);
  localparam int unsigned FUZZY_W = 9;
  localparam int unsigned ADD_W   = 6;
  localparam int unsigned SCORE_W = 13;

  localparam int unsigned SUBSTRING_BASE = 3000;
  localparam int unsigned EMPTY_SCORE    = 1000;
  localparam int unsigned MATCH_BONUS    = 10;
  localparam int unsigned CONSEC_BONUS   = 15;
  localparam int unsigned BOUNDARY_BONUS = 10;

  typedef logic [CHAR_W-1:0] char_t;

  typedef enum logic [1:0] {
    REG_PATTERN_LENGTH = 2'd0,
    REG_PATTERN_LOW    = 2'd1,
    REG_PATTERN_HIGH   = 2'd2
  } reg_index_e;

  typedef enum logic [1:0] {
    KIND_NONE        = 2'd0,
    KIND_SUBSEQUENCE = 2'd1,
    KIND_SUBSTRING   = 2'd2,
    KIND_EMPTY       = 2'd3
  } match_kind_e;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    match_kind_e               kind;
    logic                      overflow;
  } result_t;

  // Pattern character k out of the two packed pattern words.
  function automatic char_t pattern_char(logic [WORD_W-1:0] lo, logic [WORD_W-1:0] hi,
                                         logic [SLOT_W-1:0] k);
    logic [WORD_W-1:0] word;
    word = k[SLOT_W-1] ? hi : lo;
    return word[CHAR_W*k[SLOT_W-2:0] +: CHAR_W];
  endfunction

  function automatic logic is_boundary(char_t c);
    return (c == CHAR_W'("/")) || (c == CHAR_W'("\\")) ||
           (c == CHAR_W'("_")) || (c == CHAR_W'("."));
  endfunction

endpackage

`default_nettype wire

// File: hdl/fss_cell.sv
// ----------------------------------------------------------------------------
// Fuzzy subsequence scorer window cell
// One slot of the recent-character window with its pattern comparator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fss_cell (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             shift_i,
  input  wire             clear_i,
  input  fss_pkg::char_t  char_i,
  input  fss_pkg::char_t  pat_char_i,
  output fss_pkg::char_t  char_o,
  output logic            hit_o
);
  import fss_pkg::*;

  char_t char_q;
  char_t char_d;

  // The character entering this slot is the one that the window holds here
  // after the shift, so the comparison looks at the incoming character.
  assign hit_o = (char_i == pat_char_i);

  always_comb begin
    char_d = char_q;
    if (clear_i) begin
      char_d = '0;
    end else if (shift_i) begin
      char_d = char_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_q <= '0;
    end else begin
      char_q <= char_d;
    end
  end

  assign char_o = char_q;

endmodule

`default_nettype wire

// File: hdl/fss_out_buf.sv
// ----------------------------------------------------------------------------
// Fuzzy subsequence scorer output buffer
// Output register plus skid register between the scorer and the receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fss_out_buf (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               push_i,
  input  fss_pkg::result_t  push_data_i,
  output logic              full_o,
  output logic              out_valid_o,
  input  wire               out_stall_i,
  output fss_pkg::result_t  out_data_o
);
  import fss_pkg::*;

  `include "fuzzy_subsequence_scorer_defines.svh"

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_data_q, out_data_d;
  result_t skid_data_q, skid_data_d;
  logic    out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (out_free) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_data_d   = skid_data_q;
        skid_valid_d = push_i;
        skid_data_d  = push_data_i;
      end else begin
        out_valid_d = push_i;
        out_data_d  = push_data_i;
      end
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_data_d  = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `FSS_ASSERT_SAME(a_skid_behind_out, skid_valid_q, out_valid_q,
                   "skid register holds a result while the output register is empty")
  `FSS_ASSERT_NEXT(a_no_push_when_full, skid_valid_q && push_i, 1'b0,
                   "result pushed while both buffer slots were taken")

endmodule

`default_nettype wire

// File: hdl/fuzzy_subsequence_scorer.sv
// ----------------------------------------------------------------------------
// Fuzzy subsequence scorer
// Streams the characters of a text and scores it against a stored pattern.
// ----------------------------------------------------------------------------
// Usage: the pattern is written through the cfg port (index 0 length, 1 and
// 2 the packed characters) while no text is in flight. Text characters then
// arrive on the input channel, one request per cycle while in_stall_o is low;
// char_valid_i marks a real character and end_of_text_i closes the text. Each
// request that carries end_of_text_i produces exactly one result request on
// the output channel, by way of the output buffer; other requests produce none.
// Throughput is one input request per cycle while in_stall_o is low: every
// character goes through the window cells and the greedy step combinationally,
// and the score is formed in the same cycle as the closing request.
// Reset clears all text state, sets the pattern length to zero (empty
// pattern) and empties the output buffer. When the receiver stalls, results
// collect in a two-entry output buffer; in_stall_o rises only once both
// entries are taken, so up to two finished results can wait while input
// requests keep flowing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fuzzy_subsequence_scorer (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  // configuration write port
  input  wire                                cfg_we_i,
  input  wire  [1:0]                         cfg_index_i,
  input  wire  [fss_pkg::WORD_W-1:0]         cfg_wdata_i,
  // input channel
  input  wire                                in_valid_i,
  output logic                               in_stall_o,
  input  wire  [fss_pkg::CHAR_W-1:0]         text_char_i,
  input  wire                                char_valid_i,
  input  wire                                end_of_text_i,
  // output channel
  output logic                               out_valid_o,
  input  wire                                out_stall_i,
  output logic signed [fss_pkg::SCORE_W-1:0] match_score_o,
  output logic [1:0]                         match_kind_o,
  output logic                               text_overflow_o
);
  import fss_pkg::*;

  `include "fuzzy_subsequence_scorer_defines.svh"

  // Configuration registers.
  logic [LEN_W-1:0]  pat_len_q;
  logic [WORD_W-1:0] pat_lo_q;
  logic [WORD_W-1:0] pat_hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_len_q <= '0;
      pat_lo_q  <= '0;
      pat_hi_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_PATTERN_LENGTH: pat_len_q <= cfg_wdata_i[LEN_W-1:0];
        REG_PATTERN_LOW:    pat_lo_q  <= cfg_wdata_i;
        REG_PATTERN_HIGH:   pat_hi_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // A length above the pattern capacity behaves as the full capacity.
  logic [LEN_W-1:0] act_len;
  assign act_len = (pat_len_q > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : pat_len_q;

  // Handshake.
  logic buf_full;
  logic in_acc;
  logic take;
  logic finish;

  assign in_stall_o = buf_full;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign take       = in_acc && char_valid_i;
  assign finish     = in_acc && end_of_text_i;

  // Window of the most recent characters, one cell per slot, newest in cell
  // zero. Each cell compares its incoming character against the pattern
  // character that an occurrence ending at the current character would put
  // in that slot, so the AND of the used cells flags a substring match.
  char_t                  win_char [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] cell_hit;
  logic [PATTERN_MAX-1:0] cell_used;

  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    char_t             cell_in;
    char_t             cell_pat;
    logic [LEN_W-1:0]  pat_slot;

    assign pat_slot     = act_len - LEN_W'(k) - LEN_W'(1);
    assign cell_pat     = pattern_char(pat_lo_q, pat_hi_q, pat_slot[SLOT_W-1:0]);
    assign cell_used[k] = (LEN_W'(k) < act_len);

    if (k == 0) begin : g_head
      assign cell_in = text_char_i;
    end else begin : g_link
      assign cell_in = win_char[k-1];
    end

    fss_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .shift_i    (take),
      .clear_i    (finish),
      .char_i     (cell_in),
      .pat_char_i (cell_pat),
      .char_o     (win_char[k]),
      .hit_o      (cell_hit[k])
    );
  end

  // Per-text state.
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [LEN_W-1:0]   prog_q, prog_d;
  logic               prev_match_q, prev_match_d;
  logic [FUZZY_W-1:0] fuzzy_q, fuzzy_d;
  logic               found_q, found_d;
  logic [IDX_W-1:0]   first_q, first_d;
  logic               ovf_q, ovf_d;

  logic [IDX_W-1:0] cur_idx;
  logic             greedy_hit;
  logic [ADD_W-1:0] add;
  logic             occ_match;
  char_t            next_pat;

  // Position of the current character, held at the last index once the
  // text runs past its limit.
  assign cur_idx = (pos_q > POS_W'(TEXT_MAX - 1)) ? IDX_W'(TEXT_MAX - 1) : pos_q[IDX_W-1:0];

  // Greedy step: the next unmatched pattern character is taken at the first
  // text character equal to it.
  assign next_pat   = pattern_char(pat_lo_q, pat_hi_q, prog_q[SLOT_W-1:0]);
  assign greedy_hit = (prog_q < act_len) && (text_char_i == next_pat);

  // Match bonus, plus a bonus for a consecutive match (the text start counts as
  // following one) and for a match at a word boundary or at the text start.
  assign add = ADD_W'(MATCH_BONUS) +
               (prev_match_q ? ADD_W'(CONSEC_BONUS) : ADD_W'(0)) +
               (((pos_q == '0) || is_boundary(win_char[0])) ? ADD_W'(BOUNDARY_BONUS)
                                                             : ADD_W'(0));

  // A contiguous occurrence needs as many characters as the pattern has.
  assign occ_match = (act_len != '0) &&
                     ((pos_q + POS_W'(1)) >= POS_W'(act_len)) &&
                     ((cell_hit | ~cell_used) == '1);

  always_comb begin
    pos_d        = pos_q;
    prog_d       = prog_q;
    prev_match_d = prev_match_q;
    fuzzy_d      = fuzzy_q;
    found_d      = found_q;
    first_d      = first_q;
    ovf_d        = ovf_q;
    if (take) begin
      if (pos_q >= POS_W'(TEXT_MAX)) begin
        ovf_d = 1'b1;
      end else begin
        pos_d = pos_q + POS_W'(1);
      end
      prev_match_d = greedy_hit;
      if (greedy_hit) begin
        fuzzy_d = fuzzy_q + FUZZY_W'(add);
        prog_d  = prog_q + LEN_W'(1);
      end
      if (!found_q && occ_match) begin
        found_d = 1'b1;
        first_d = cur_idx - IDX_W'(act_len) + IDX_W'(1);
      end
    end
  end

  // Score of the text as it stands after the current request.
  result_t res;

  always_comb begin
    res.score    = '0;
    res.kind     = KIND_NONE;
    res.overflow = ovf_d;
    if (act_len == '0) begin
      res.score = SCORE_W'(EMPTY_SCORE);
      res.kind  = KIND_EMPTY;
    end else if (found_d) begin
      res.score = SCORE_W'(SUBSTRING_BASE) - SCORE_W'(first_d);
      res.kind  = KIND_SUBSTRING;
    end else if (prog_d >= act_len) begin
      res.score = SCORE_W'(fuzzy_d);
      res.kind  = KIND_SUBSEQUENCE;
    end
  end

  // The closing request returns every piece of text state to its reset value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      prog_q       <= '0;
      prev_match_q <= 1'b1;
      fuzzy_q      <= '0;
      found_q      <= 1'b0;
      first_q      <= '0;
      ovf_q        <= 1'b0;
    end else if (finish) begin
      pos_q        <= '0;
      prog_q       <= '0;
      prev_match_q <= 1'b1;
      fuzzy_q      <= '0;
      found_q      <= 1'b0;
      first_q      <= '0;
      ovf_q        <= 1'b0;
    end else begin
      pos_q        <= pos_d;
      prog_q       <= prog_d;
      prev_match_q <= prev_match_d;
      fuzzy_q      <= fuzzy_d;
      found_q      <= found_d;
      first_q      <= first_d;
      ovf_q        <= ovf_d;
    end
  end

  // Output buffer.
  result_t out_res;

  fss_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (finish),
    .push_data_i (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_res)
  );

  assign match_score_o   = out_res.score;
  assign match_kind_o    = out_res.kind;
  assign text_overflow_o = out_res.overflow;

  `FSS_ASSERT_SAME(a_prog_bounded, 1'b1, prog_q <= LEN_W'(PATTERN_MAX),
                   "pattern progress beyond pattern capacity")
  `FSS_ASSERT_SAME(a_pos_bounded, 1'b1, pos_q <= POS_W'(TEXT_MAX),
                   "character position beyond text limit")
  `FSS_ASSERT_NEXT(a_clear_after_result, finish,
                   pos_q == '0 && prog_q == '0 && prev_match_q && !found_q && !ovf_q,
                   "text state not cleared after a result")
  `FSS_ASSERT_NEXT(a_found_sticky, found_q && !finish, found_q,
                   "substring flag dropped within a text")

endmodule

`default_nettype wire
